@@ hdl/sri_pkg.sv @@
// Shared types and constants for the segment/rectangle intersection block.
// No dependencies; imported by sri_div and segment_rectangle_intersect_top.
package sri_pkg;

    localparam int CoordWidthDefault = 24;

    // Side information that travels with a numerator through the divider
    typedef struct packed {
        logic neg;   // displacement positive: result takes the negative sign
        logic zero;  // divisor zero: result forced to zero
    } div_ctl_t;

endpackage

@@ hdl/sri_div.sv @@
// Pipelined restoring divider with round-to-nearest, sign and saturation.
// One quotient bit per stage, CoordWidth+1 register stages. Uses sri_pkg.
module sri_div #(
    parameter int CoordWidth = sri_pkg::CoordWidthDefault
) (
    input  logic                          clk,
    input  logic                          en,
    input  logic [2*CoordWidth+1:0]       num,
    input  logic [CoordWidth+2:0]         den,
    input  sri_pkg::div_ctl_t             ctl,
    output logic signed [CoordWidth-1:0]  res
);
    import sri_pkg::*;

    localparam int W  = CoordWidth;
    localparam int NW = 2 * W + 2;
    localparam int SW = W + 3;

    logic [NW-1:0] rem_reg [0:W];
    logic [W-1:0]  quo_reg [0:W];
    logic [SW-1:0] den_reg [0:W];
    div_ctl_t      ctl_reg [0:W];

    logic [NW:0]   rem2;
    logic [W:0]    qr;
    logic [W:0]    max_pos;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= num;
            quo_reg[0] <= '0;
            den_reg[0] <= den;
            ctl_reg[0] <= ctl;
        end
    end

    // numerator <= 2^(W-1) * divisor, so the quotient fits W bits
    for (genvar j = 0; j < W; j++)
    begin : g_step
        logic [NW-1:0] dsh;
        logic          ge;

        assign dsh = {{(NW-SW){1'b0}}, den_reg[j]} << (W - 1 - j);
        assign ge  = rem_reg[j] >= dsh;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j+1] <= ge ? rem_reg[j] - dsh : rem_reg[j];
                quo_reg[j+1] <= quo_reg[j] | (W'(ge) << (W - 1 - j));
                den_reg[j+1] <= den_reg[j];
                ctl_reg[j+1] <= ctl_reg[j];
            end
        end
    end

    assign max_pos = {2'b00, {(W-1){1'b1}}};

    always_comb
    begin
        rem2 = {rem_reg[W], 1'b0};
        qr   = {1'b0, quo_reg[W]} + (W+1)'(rem2 >= {{(NW+1-SW){1'b0}}, den_reg[W]});
        if (ctl_reg[W].zero)
            res = '0;
        else if (ctl_reg[W].neg)
            res = W'(-qr);
        else if (qr > max_pos)
            res = max_pos[W-1:0];
        else
            res = qr[W-1:0];
    end

endmodule

@@ hdl/segment_rectangle_intersect_top.sv @@
// Segment versus axis-aligned rectangle intersection, top level.
// Depends on sri_pkg and sri_div.
//
// Usage: one request on the input channel (in_valid/in_stall) carries a
// segment start, displacement, rectangle corner and size, all Q16.8. One
// result leaves on the output channel (out_valid/out_stall): hit, and either
// the displacement (miss) or the reflected part -(move*t) of the last edge
// touched, edges checked top, right, bottom, left.
// Throughput: one request per cycle while the output is not stalled.
// Pipeline: three stages for differences, products and edge selection, the
// numerator multiply into the divider input register, one divider stage per
// quotient bit, then rounding into the output register.
// Stall: while a result sits in the output register with out_stall high the
// whole pipeline holds and in_stall is raised; nothing is dropped or repeated.
// Reset: all valid bits clear; the pipeline comes out empty.
module segment_rectangle_intersect_top #(
    parameter int COORD_WIDTH = sri_pkg::CoordWidthDefault
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [COORD_WIDTH-1:0] start_x,
    input  logic signed [COORD_WIDTH-1:0] start_y,
    input  logic signed [COORD_WIDTH-1:0] move_x,
    input  logic signed [COORD_WIDTH-1:0] move_y,
    input  logic signed [COORD_WIDTH-1:0] box_x,
    input  logic signed [COORD_WIDTH-1:0] box_y,
    input  logic [COORD_WIDTH-2:0]        box_w,
    input  logic [COORD_WIDTH-2:0]        box_h,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          hit,
    output logic signed [COORD_WIDTH-1:0] out_x,
    output logic signed [COORD_WIDTH-1:0] out_y
);
    import sri_pkg::*;

    localparam int W  = COORD_WIDTH;
    localparam int PW = 2 * W + 2;
    localparam int NW = 2 * W + 2;
    localparam int SW = W + 3;

    function automatic logic [W+1:0] mag_e(input logic signed [W+2:0] v);
        logic [W+2:0] t;
        t = v[W+2] ? -v : v;
        return t[W+1:0];
    endfunction

    logic en;

    // stage 1: corner offsets from the start point
    logic                 s1_vld_reg;
    logic signed [W+1:0]  s1_ex0_reg, s1_ex1_reg, s1_ey0_reg, s1_ey1_reg;
    logic signed [W+1:0]  s1_ex0_next, s1_ex1_next, s1_ey0_next, s1_ey1_next;
    logic signed [W-1:0]  s1_vx_reg, s1_vy_reg;
    logic                 s1_wz_reg, s1_hz_reg;
    logic signed [W+1:0]  px_e, py_e, bx_e, by_e, bw_e, bh_e;

    // stage 2: products and line distances
    logic                 s2_vld_reg;
    logic signed [PW-1:0] s2_pvx0_reg, s2_pvx1_reg, s2_pvy0_reg, s2_pvy1_reg;
    logic signed [PW-1:0] s2_pvx0_next, s2_pvx1_next, s2_pvy0_next, s2_pvy1_next;
    logic signed [W+2:0]  s2_e_reg [0:3];
    logic signed [W+2:0]  s2_f_reg [0:3];
    logic signed [W+2:0]  s2_e_next [0:3];
    logic signed [W+2:0]  s2_f_next [0:3];
    logic signed [W-1:0]  s2_vx_reg, s2_vy_reg;
    logic                 s2_wz_reg, s2_hz_reg;

    // stage 3: edge tests and last-hit selection
    logic                 s3_vld_reg, s3_hit_reg;
    logic                 s3_hit_next;
    logic [W+1:0]         s3_a_reg, s3_b_reg, s3_a_next, s3_b_next;
    logic signed [W-1:0]  s3_vx_reg, s3_vy_reg;
    logic signed [PW:0]   cr [0:3];

    // numerator multiply feeding the dividers
    logic [W-1:0]         mx, my;
    logic [NW-1:0]        num_x, num_y;
    logic [SW-1:0]        den;
    div_ctl_t             ctl_x, ctl_y;
    logic signed [W-1:0]  res_x, res_y;

    logic                 dv_vld_reg [0:W];
    logic                 dv_hit_reg [0:W];
    logic signed [W-1:0]  dv_vx_reg [0:W];
    logic signed [W-1:0]  dv_vy_reg [0:W];

    logic                 out_vld_reg, hit_reg;
    logic signed [W-1:0]  out_x_reg, out_y_reg;

    assign en        = !(out_vld_reg && out_stall);
    assign in_stall  = out_vld_reg && out_stall;
    assign out_valid = out_vld_reg;
    assign hit       = hit_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;

    // ---------------- stage 1 ----------------
    always_comb
    begin
        px_e = {{2{start_x[W-1]}}, start_x};
        py_e = {{2{start_y[W-1]}}, start_y};
        bx_e = {{2{box_x[W-1]}}, box_x};
        by_e = {{2{box_y[W-1]}}, box_y};
        bw_e = {3'b000, box_w};
        bh_e = {3'b000, box_h};
        s1_ex0_next = bx_e - px_e;
        s1_ex1_next = bx_e + bw_e - px_e;
        s1_ey0_next = by_e - py_e;
        s1_ey1_next = by_e + bh_e - py_e;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_ex0_reg <= s1_ex0_next;
            s1_ex1_reg <= s1_ex1_next;
            s1_ey0_reg <= s1_ey0_next;
            s1_ey1_reg <= s1_ey1_next;
            s1_vx_reg  <= move_x;
            s1_vy_reg  <= move_y;
            s1_wz_reg  <= box_w == '0;
            s1_hz_reg  <= box_h == '0;
        end
    end

    // ---------------- stage 2 ----------------
    always_comb
    begin
        s2_pvx0_next = s1_vx_reg * s1_ey0_reg;
        s2_pvx1_next = s1_vx_reg * s1_ey1_reg;
        s2_pvy0_next = s1_vy_reg * s1_ex0_reg;
        s2_pvy1_next = s1_vy_reg * s1_ex1_reg;
        // e: start point to edge line, f: end point to edge line (both negated)
        s2_e_next[0] = {s1_ey0_reg[W+1], s1_ey0_reg};
        s2_e_next[1] = {s1_ex1_reg[W+1], s1_ex1_reg};
        s2_e_next[2] = {s1_ey1_reg[W+1], s1_ey1_reg};
        s2_e_next[3] = {s1_ex0_reg[W+1], s1_ex0_reg};
        s2_f_next[0] = s2_e_next[0] - {{3{s1_vy_reg[W-1]}}, s1_vy_reg};
        s2_f_next[1] = s2_e_next[1] - {{3{s1_vx_reg[W-1]}}, s1_vx_reg};
        s2_f_next[2] = s2_e_next[2] - {{3{s1_vy_reg[W-1]}}, s1_vy_reg};
        s2_f_next[3] = s2_e_next[3] - {{3{s1_vx_reg[W-1]}}, s1_vx_reg};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_pvx0_reg <= s2_pvx0_next;
            s2_pvx1_reg <= s2_pvx1_next;
            s2_pvy0_reg <= s2_pvy0_next;
            s2_pvy1_reg <= s2_pvy1_next;
            for (int k = 0; k < 4; k++)
            begin
                s2_e_reg[k] <= s2_e_next[k];
                s2_f_reg[k] <= s2_f_next[k];
            end
            s2_vx_reg <= s1_vx_reg;
            s2_vy_reg <= s1_vy_reg;
            s2_wz_reg <= s1_wz_reg;
            s2_hz_reg <= s1_hz_reg;
        end
    end

    // ---------------- stage 3 ----------------
    // cross of displacement with each corner offset, corners in edge order
    always_comb
    begin
        cr[0] = {s2_pvx0_reg[PW-1], s2_pvx0_reg} - {s2_pvy0_reg[PW-1], s2_pvy0_reg};
        cr[1] = {s2_pvx0_reg[PW-1], s2_pvx0_reg} - {s2_pvy1_reg[PW-1], s2_pvy1_reg};
        cr[2] = {s2_pvx1_reg[PW-1], s2_pvx1_reg} - {s2_pvy1_reg[PW-1], s2_pvy1_reg};
        cr[3] = {s2_pvx1_reg[PW-1], s2_pvx1_reg} - {s2_pvy0_reg[PW-1], s2_pvy0_reg};
    end

    always_comb
    begin
        logic miss1, miss2, degen;
        int   kn;
        s3_hit_next = 1'b0;
        s3_a_next   = '0;
        s3_b_next   = '0;
        for (int k = 0; k < 4; k++)
        begin
            kn    = (k == 3) ? 0 : k + 1;
            degen = (k == 0 || k == 2) ? s2_wz_reg : s2_hz_reg;
            miss1 = (cr[k] != '0) && (cr[kn] != '0) && (cr[k][PW] == cr[kn][PW]);
            miss2 = !degen && (s2_e_reg[k] != '0) && (s2_f_reg[k] != '0)
                    && (s2_e_reg[k][W+2] == s2_f_reg[k][W+2]);
            // later edges override earlier ones
            if (!miss1 && !miss2)
            begin
                s3_hit_next = 1'b1;
                s3_a_next   = degen ? '0 : mag_e(s2_e_reg[k]);
                s3_b_next   = degen ? '0 : mag_e(s2_f_reg[k]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_hit_reg <= s3_hit_next;
            s3_a_reg   <= s3_a_next;
            s3_b_reg   <= s3_b_next;
            s3_vx_reg  <= s2_vx_reg;
            s3_vy_reg  <= s2_vy_reg;
        end
    end

    // ---------------- numerators and divisor ----------------
    always_comb
    begin
        mx    = s3_vx_reg[W-1] ? W'(-s3_vx_reg) : W'(s3_vx_reg);
        my    = s3_vy_reg[W-1] ? W'(-s3_vy_reg) : W'(s3_vy_reg);
        num_x = mx * s3_a_reg;
        num_y = my * s3_a_reg;
        den   = {1'b0, s3_a_reg} + {1'b0, s3_b_reg};
        ctl_x.neg  = !s3_vx_reg[W-1] && (s3_vx_reg != '0);
        ctl_x.zero = den == '0;
        ctl_y.neg  = !s3_vy_reg[W-1] && (s3_vy_reg != '0);
        ctl_y.zero = den == '0;
    end

    sri_div #(.CoordWidth(W)) u_div_x (
        .clk (clk),
        .en  (en),
        .num (num_x),
        .den (den),
        .ctl (ctl_x),
        .res (res_x)
    );

    sri_div #(.CoordWidth(W)) u_div_y (
        .clk (clk),
        .en  (en),
        .num (num_y),
        .den (den),
        .ctl (ctl_y),
        .res (res_y)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_hit_reg[0] <= s3_hit_reg;
            dv_vx_reg[0]  <= s3_vx_reg;
            dv_vy_reg[0]  <= s3_vy_reg;
            for (int i = 0; i < W; i++)
            begin
                dv_hit_reg[i+1] <= dv_hit_reg[i];
                dv_vx_reg[i+1]  <= dv_vx_reg[i];
                dv_vy_reg[i+1]  <= dv_vy_reg[i];
            end
            hit_reg   <= dv_hit_reg[W];
            out_x_reg <= dv_hit_reg[W] ? res_x : dv_vx_reg[W];
            out_y_reg <= dv_hit_reg[W] ? res_y : dv_vy_reg[W];
        end
    end

    // ---------------- valid bits ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            for (int i = 0; i <= W; i++)
                dv_vld_reg[i] <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg    <= in_valid;
            s2_vld_reg    <= s1_vld_reg;
            s3_vld_reg    <= s2_vld_reg;
            dv_vld_reg[0] <= s3_vld_reg;
            for (int i = 0; i < W; i++)
                dv_vld_reg[i+1] <= dv_vld_reg[i];
            out_vld_reg   <= dv_vld_reg[W];
        end
    end

    // ---------------- assertions ----------------
    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(s1_vld_reg) && $stable(s3_vld_reg) && $stable(dv_vld_reg[W]))
        else $error("pipeline moved while stalled");

    a_quotient_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (s3_vld_reg && !ctl_x.zero) |->
            ((num_x >> (W - 1)) <= {{(NW-SW){1'b0}}, den})
            && ((num_y >> (W - 1)) <= {{(NW-SW){1'b0}}, den}))
        else $error("numerator too large for divider");

    a_miss_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (s3_vld_reg && !s3_hit_reg) |-> (s3_a_reg == '0) && (s3_b_reg == '0))
        else $error("edge distances set without a hit");

endmodule

@@ dv/tb_segment_rectangle_intersect_top.sv @@
// Testbench for segment_rectangle_intersect_top: random and directed segment/box
// requests, expected hit and reflected vector computed in a local predictor.
// Depends on sri_pkg and the block's RTL only.
module tb_segment_rectangle_intersect_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW = sri_pkg::CoordWidthDefault;
    localparam longint OUT_MAX = (64'sd1 <<< (CW - 1)) - 1;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct {
        logic          hit;
        logic [CW-1:0] x;
        logic [CW-1:0] y;
    } bounce_t;

    // exact cross product a x b
    function automatic logic signed [127:0] cross2(longint ax, longint ay,
                                                  longint bx, longint by);
        logic signed [127:0] p, q;
        p = 128'(ax) * 128'(by);
        q = 128'(ay) * 128'(bx);
        return p - q;
    endfunction

    function automatic int sgn(logic signed [127:0] v);
        if (v < 0) return -1;
        return (v == 0) ? 0 : 1;
    endfunction

    // -(m * a1 / total), magnitude rounded half away from zero, clamped
    function automatic longint bounce_part(longint m, logic signed [127:0] a1,
                                           logic signed [127:0] total);
        logic [127:0] num, q, r;
        longint mag;
        if (total == 0) return 0;
        mag = (m < 0) ? -m : m;
        num = 128'(a1) * 128'(mag);
        q = num / 128'(total);
        r = num % 128'(total);
        if (2 * r >= 128'(total)) q = q + 1;
        if (m > 0) return -longint'(q);
        return (longint'(q) > OUT_MAX) ? OUT_MAX : longint'(q);
    endfunction

    function automatic bounce_t predict_bounce(logic signed [CW-1:0] sx, sy, mx, my, bx, by,
                                               logic [CW-2:0] bw, bh);
        longint px, py, vx, vy, ex, ey, lx, ly, rx, ry;
        longint kx[5], ky[5];
        logic signed [127:0] c1, c2, a1, a2;
        bounce_t res;
        px = sx; py = sy; vx = mx; vy = my;
        kx[0] = bx;                     ky[0] = by;
        kx[1] = kx[0] + longint'(bw);   ky[1] = ky[0];
        kx[2] = kx[1];                  ky[2] = ky[0] + longint'(bh);
        kx[3] = kx[0];                  ky[3] = ky[2];
        kx[4] = kx[0];                  ky[4] = ky[0];
        rx = vx; ry = vy;
        res.hit = 1'b0;
        for (int k = 0; k < 4; k++)
        begin
            ex = kx[k+1]; ey = ky[k+1];
            c1 = cross2(vx, vy, ex - px, ey - py);
            c2 = cross2(vx, vy, kx[k] - px, ky[k] - py);
            if (sgn(c1) * sgn(c2) > 0) continue;
            lx = ex - kx[k]; ly = ey - ky[k];
            c1 = cross2(lx, ly, px - kx[k], py - ky[k]);
            c2 = cross2(lx, ly, px + vx - kx[k], py + vy - ky[k]);
            if (sgn(c1) * sgn(c2) > 0) continue;
            a1 = (c1 < 0) ? -c1 : c1;
            a2 = (c2 < 0) ? -c2 : c2;
            rx = bounce_part(vx, a1, a1 + a2);
            ry = bounce_part(vy, a1, a1 + a2);
            res.hit = 1'b1;
        end
        res.x = rx[CW-1:0];
        res.y = ry[CW-1:0];
        return res;
    endfunction

    class bounce_board;
        bounce_t pending[$];
        int errors;

        function void report_mismatch(string msg);
            $display("MISMATCH @%0t: %s", $realtime, msg);
            errors++;
        endfunction

        function void note_request(bounce_t b);
            pending.push_back(b);
        endfunction

        function void check_result(logic h, logic [CW-1:0] ox, oy);
            bounce_t e;
            if (pending.size() == 0)
            begin
                report_mismatch("result with none pending");
                return;
            end
            e = pending.pop_front();
            if (h !== e.hit)
                report_mismatch($sformatf("hit %b want %b", h, e.hit));
            if (ox !== e.x)
                report_mismatch($sformatf("out_x %h want %h", ox, e.x));
            if (oy !== e.y)
                report_mismatch($sformatf("out_y %h want %h", oy, e.y));
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0, out_stall = 1'b0;
    logic in_stall, out_valid, hit;
    logic signed [CW-1:0] start_x = '0, start_y = '0, move_x = '0, move_y = '0;
    logic signed [CW-1:0] box_x = '0, box_y = '0, out_x, out_y;
    logic [CW-2:0] box_w = '0, box_h = '0;

    bounce_board board = new();
    bit quiet = 1'b0;     // no idling in the last part of the run
    bit hold_off = 1'b0;  // long receiver stall
    int idle_cycles = 0;

    always #4 clk = ~clk;

    segment_rectangle_intersect_top u_top (.*);

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            board.note_request(predict_bounce(start_x, start_y, move_x, move_y,
                                              box_x, box_y, box_w, box_h));
        if (rst_n && out_valid && !out_stall)
            board.check_result(hit, out_x, out_y);
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // receiver stall bursts
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off)
                out_stall <= 1'b1;
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 4)) @(posedge clk);
                out_stall <= 1'b0;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // offer one request and hold it until accepted; high bits are dropped
    task automatic send_request(int sx, sy, mx, my, bx, by, bw, bh);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        start_x <= CW'(sx); start_y <= CW'(sy); move_x <= CW'(mx); move_y <= CW'(my);
        box_x <= CW'(bx); box_y <= CW'(by); box_w <= (CW-1)'(bw); box_h <= (CW-1)'(bh);
        do @(posedge clk); while (in_stall);
    endtask

    // mostly small scenes near the box so edges are hit; some full range
    task automatic send_random();
        int bx, by, sx, sy, mx, my;
        int bw, bh;
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 2)
        begin
            send_request($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                         $urandom, $urandom);
            return;
        end
        bx = $urandom; by = $urandom;
        bw = (sel < 5) ? $urandom_range(0, 4096) : $urandom_range(0, 16);
        bh = (sel < 5) ? $urandom_range(0, 4096) : $urandom_range(0, 16);
        sx = bx + int'($urandom_range(0, 8192)) - 2048;
        sy = by + int'($urandom_range(0, 8192)) - 2048;
        mx = int'($urandom_range(0, 12000)) - 6000;
        my = int'($urandom_range(0, 12000)) - 6000;
        if (sel == 9)
            my = 0;  // horizontal: parallel to the top and bottom edges
        send_request(sx, sy, mx, my, bx, by, bw, bh);
    endtask

    localparam int MINV = -(2 ** (CW - 1));
    localparam int MAXV = (2 ** (CW - 1)) - 1;
    localparam int WMAX = (2 ** (CW - 1)) - 1;

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // directed: crossing, miss, corner touch, collinear, extremes
        send_request(0, 512, 2048, 0, 256, 0, 512, 1024);
        send_request(0, 0, 256, 256, 4096, 4096, 256, 256);
        send_request(0, 0, 256, 256, 256, 256, 256, 256);
        send_request(0, 0, 1024, 0, 256, 0, 256, 256);
        send_request(256, 0, 0, 0, 256, 0, 256, 256);
        send_request(0, 0, 0, 0, 0, 0, 0, 0);
        send_request(MAXV, 0, MINV, 0, 0, MINV, 0, WMAX);
        send_request(MINV, 0, MAXV, 0, 0, MINV, 0, WMAX);
        send_request(0, 0, MINV, MINV, MINV, MINV, WMAX, WMAX);
        send_request(MINV, MINV, MAXV, MAXV, MAXV, MAXV, WMAX, WMAX);
        send_request(0, MINV, 0, MAXV, MINV, 0, WMAX, WMAX);
        send_request(MAXV, MAXV, MINV, MINV, 0, 0, 0, 0);
        send_request(0, 0, MINV, 0, MINV, MINV, 0, WMAX);
        send_request(-256, 128, 512, 0, 0, 0, 512, 256);
        for (int i = 0; i < 800; i++)
            send_random();
        // fill the pipeline against a held receiver
        hold_off = 1'b1;
        for (int i = 0; i < 60; i++)
            send_random();
        for (int i = 0; i < 700; i++)
            send_random();
        quiet = 1'b1;
        for (int i = 0; i < 150; i++)
            send_random();
        in_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge clk);
        repeat (CW + 10) @(posedge clk);
        if (board.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // release the long hold once the input side has backed up
    initial
    begin
        wait (hold_off);
        repeat (200) @(posedge clk);
        hold_off = 1'b0;
    end
endmodule
